### rtl/ura_pkg.sv
// Shared types and constants for the ultrasonic range averager.
package ura_pkg;

  localparam int PhaseW = 3;
  localparam logic [PhaseW-1:0] PH_IDLE  = 3'd0;
  localparam logic [PhaseW-1:0] PH_TLOW  = 3'd1;
  localparam logic [PhaseW-1:0] PH_THIGH = 3'd2;
  localparam logic [PhaseW-1:0] PH_WAIT  = 3'd3;
  localparam logic [PhaseW-1:0] PH_PULSE = 3'd4;
  localparam logic [PhaseW-1:0] PH_GAP   = 3'd5;
  localparam logic [PhaseW-1:0] PH_SETUP = 3'd6;

  localparam logic [15:0] LOW_TICKS  = 16'd5;
  localparam logic [15:0] HIGH_TICKS = 16'd10;
  localparam logic [15:0] TICK_MAX   = 16'hFFFF;
  localparam logic [23:0] DIST_MAX   = 24'd16383;

  localparam int CfgAddrW = 2;
  localparam logic [CfgAddrW-1:0] REG_SAMPLE_COUNT = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_ECHO_TIMEOUT = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_GAP          = 2'd2;

  localparam logic [7:0]  RST_SAMPLE_COUNT = 8'd3;
  localparam logic [15:0] RST_ECHO_TIMEOUT = 16'd29000;
  localparam logic [15:0] RST_GAP          = 16'd50000;

  localparam int DivW     = 24;
  localparam int DivSteps = 24;
  localparam int CntW     = 5;

  typedef struct packed {
    logic [13:0] distance_mm;
    logic        fail;
    logic        done_res;
    logic        busy_res;
    logic        trigger_level;
  } result_t;

endpackage

### rtl/ultrasonic_range_averager_core.sv
// Echo-ranging controller that averages several pings, one item per microsecond tick.
// An ordinary tick item is registered and loaded into the output register in S_PUSH; the
// next item is taken after that. The tick that closes a run uses a 24-step shared restoring
// divider to compute the average, one shift-add step scales by ten, the same divider divides
// by US_PER_CM, one step saturates and one loads the output register. A stalled output delays
// the next item. Synchronous active-low reset restores all but result and divider registers.
module ultrasonic_range_averager_core #(
  parameter int US_PER_CM   = 58,
  parameter int MAX_SAMPLES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // Bits from 0: start_req, echo_level, zero fill.
  input  logic [7:0]                   in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // Bits from 0: trigger_level, busy_res, done_res, fail, distance_mm[13:0], zero fill.
  output logic [23:0]                  out_tdata,
  input  logic                         cfg_we,
  input  logic [ura_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [15:0]                  cfg_wdata
);
  import ura_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV_A = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV_B = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_PUSH  = 3'd5;

  logic [2:0]        seq_r, seq_nxt;
  logic [7:0]        samples_r, samples_nxt;
  logic [15:0]       timeout_r, timeout_nxt;
  logic [15:0]       gap_r, gap_nxt;
  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [15:0]       tick_r, tick_nxt;
  logic [15:0]       pw_r, pw_nxt;
  logic [19:0]       sum_r, sum_nxt;
  logic [4:0]        pings_r, pings_nxt;
  logic [13:0]       last_r, last_nxt;
  result_t           res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_data_r, out_data_nxt;
  logic [DivW-1:0]   quo_r, quo_nxt;
  logic [7:0]        rem_r, rem_nxt;
  logic [7:0]        div_r, div_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;

  logic        accept;
  logic        start_req, echo_level;
  logic [7:0]  clamped;
  logic [15:0] tick_inc, pw_inc;
  logic        failed;
  logic [8:0]  rem_sh;
  logic [7:0]  rem_sub;
  logic        ge;
  logic [7:0]  rem_step;
  logic [DivW-1:0] quo_step;
  logic        last_step;
  logic        out_free;

  assign in_tready  = (seq_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign start_req  = in_tdata[0];
  assign echo_level = in_tdata[1];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_data_r};
  assign out_free   = !out_valid_r || out_tready;

  assign clamped  = (samples_r > 8'(MAX_SAMPLES)) ? 8'(MAX_SAMPLES) : samples_r;
  assign tick_inc = (tick_r < TICK_MAX) ? tick_r + 16'd1 : tick_r;
  assign pw_inc   = (pw_r < TICK_MAX) ? pw_r + 16'd1 : pw_r;

  assign rem_sh    = {rem_r, quo_r[DivW-1]};
  assign rem_sub   = rem_sh[7:0] - div_r;
  assign ge        = (rem_sh >= {1'b0, div_r});
  assign rem_step  = ge ? rem_sub : rem_sh[7:0];
  assign quo_step  = {quo_r[DivW-2:0], ge};
  assign last_step = (cnt_r == CntW'(DivSteps - 1));

  always_comb begin
    seq_nxt       = seq_r;
    samples_nxt   = samples_r;
    timeout_nxt   = timeout_r;
    gap_nxt       = gap_r;
    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    pw_nxt        = pw_r;
    sum_nxt       = sum_r;
    pings_nxt     = pings_r;
    last_nxt      = last_r;
    res_nxt       = res_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    failed        = 1'b0;

    if (cfg_we) begin
      case (cfg_addr)
        REG_SAMPLE_COUNT: samples_nxt = cfg_wdata[7:0];
        REG_ECHO_TIMEOUT: timeout_nxt = cfg_wdata;
        REG_GAP:          gap_nxt     = cfg_wdata;
        default: ;
      endcase
    end

    case (seq_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt.trigger_level = 1'b0;
          res_nxt.busy_res      = 1'b1;
          res_nxt.done_res      = 1'b0;
          res_nxt.fail          = 1'b0;
          seq_nxt               = S_PUSH;
          case (phase_r)
            PH_IDLE: begin
              res_nxt.busy_res = 1'b0;
              if (start_req) begin
                if (clamped == 8'd0) begin
                  last_nxt         = 14'd0;
                  res_nxt.done_res = 1'b1;
                end else begin
                  phase_nxt        = PH_SETUP;
                  res_nxt.busy_res = 1'b1;
                  tick_nxt         = 16'd0;
                  pw_nxt           = 16'd0;
                  sum_nxt          = 20'd0;
                  pings_nxt        = 5'd0;
                end
              end
            end
            PH_SETUP: begin
              phase_nxt = PH_TLOW;
              tick_nxt  = 16'd0;
            end
            PH_TLOW: begin
              tick_nxt = tick_r + 16'd1;
              if (tick_nxt >= LOW_TICKS) begin
                phase_nxt = PH_THIGH;
                tick_nxt  = 16'd0;
              end
            end
            PH_THIGH: begin
              res_nxt.trigger_level = 1'b1;
              tick_nxt = tick_r + 16'd1;
              if (tick_nxt >= HIGH_TICKS) begin
                phase_nxt = PH_WAIT;
                tick_nxt  = 16'd0;
                pw_nxt    = 16'd0;
              end
            end
            PH_WAIT: begin
              tick_nxt = tick_inc;
              if (tick_inc >= timeout_r) begin
                failed = 1'b1;
              end else if (echo_level) begin
                phase_nxt = PH_PULSE;
                pw_nxt    = 16'd1;
              end
            end
            PH_PULSE: begin
              if (!echo_level) begin
                sum_nxt   = sum_r + {4'd0, pw_r};
                pings_nxt = pings_r + 5'd1;
                phase_nxt = PH_GAP;
                tick_nxt  = 16'd0;
              end else begin
                tick_nxt = tick_inc;
                pw_nxt   = pw_inc;
                if (tick_inc >= timeout_r) failed = 1'b1;
              end
            end
            PH_GAP: begin
              if (tick_r < gap_r) begin
                tick_nxt = tick_r + 16'd1;
              end else if ({3'd0, pings_r} >= clamped && pings_r != 5'd0) begin
                phase_nxt        = PH_IDLE;
                res_nxt.busy_res = 1'b0;
                res_nxt.done_res = 1'b1;
                quo_nxt          = {4'd0, sum_r};
                div_nxt          = {3'd0, pings_r};
                rem_nxt          = 8'd0;
                cnt_nxt          = '0;
                seq_nxt          = S_DIV_A;
              end else begin
                phase_nxt = PH_TLOW;
                tick_nxt  = 16'd0;
              end
            end
            default: begin
              phase_nxt        = PH_IDLE;
              res_nxt.busy_res = 1'b0;
            end
          endcase
          if (failed) begin
            last_nxt         = 14'd0;
            phase_nxt        = PH_IDLE;
            tick_nxt         = 16'd0;
            res_nxt.busy_res = 1'b0;
            res_nxt.done_res = 1'b1;
            res_nxt.fail     = 1'b1;
          end
          res_nxt.distance_mm = last_nxt;
        end
      end
      S_DIV_A: begin
        quo_nxt = quo_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + CntW'(1);
        if (last_step) seq_nxt = S_MUL;
      end
      S_MUL: begin
        quo_nxt = {quo_r[DivW-4:0], 3'd0} + {quo_r[DivW-2:0], 1'b0};
        div_nxt = 8'(US_PER_CM);
        rem_nxt = 8'd0;
        cnt_nxt = '0;
        seq_nxt = S_DIV_B;
      end
      S_DIV_B: begin
        quo_nxt = quo_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + CntW'(1);
        if (last_step) seq_nxt = S_FIN;
      end
      S_FIN: begin
        last_nxt            = (quo_r > DIST_MAX) ? DIST_MAX[13:0] : quo_r[13:0];
        res_nxt.distance_mm = last_nxt;
        seq_nxt             = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          seq_nxt       = S_IDLE;
        end
      end
      default: seq_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= S_IDLE;
      samples_r   <= RST_SAMPLE_COUNT;
      timeout_r   <= RST_ECHO_TIMEOUT;
      gap_r       <= RST_GAP;
      phase_r     <= PH_IDLE;
      tick_r      <= 16'd0;
      pw_r        <= 16'd0;
      sum_r       <= 20'd0;
      pings_r     <= 5'd0;
      last_r      <= 14'd0;
      out_valid_r <= 1'b0;
    end else begin
      seq_r       <= seq_nxt;
      samples_r   <= samples_nxt;
      timeout_r   <= timeout_nxt;
      gap_r       <= gap_nxt;
      phase_r     <= phase_nxt;
      tick_r      <= tick_nxt;
      pw_r        <= pw_nxt;
      sum_r       <= sum_nxt;
      pings_r     <= pings_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    cnt_r      <= cnt_nxt;
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.done_res && out_data_r.busy_res))
    else $error("result shows done and busy together");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.fail) |-> (out_data_r.done_res && out_data_r.distance_mm == 14'd0))
    else $error("failed result without done or with a distance");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == S_DIV_A || seq_r == S_DIV_B) |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");

  a_pings_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {3'd0, pings_r} <= 8'(MAX_SAMPLES))
    else $error("ping count beyond sample limit");

endmodule

### tb/tb_ultrasonic_range_averager_core.sv
// Self-checking testbench for the ultrasonic range averager core, with an in-bench tick predictor.
`timescale 1ns / 100ps

module tb_ultrasonic_range_averager_core;
  import ura_pkg::*;

  localparam int UsPerCm    = 58;
  localparam int MaxSamples = 16;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [23:0]         out_tdata;
  logic                cfg_we     = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr   = '0;
  logic [15:0]         cfg_wdata  = '0;

  ultrasonic_range_averager_core #(
    .US_PER_CM  (UsPerCm),
    .MAX_SAMPLES(MaxSamples)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted ranger state and register copies.
  logic [PhaseW-1:0] ph       = PH_IDLE;
  logic [15:0]       tick_cnt = '0;
  logic [15:0]       pw       = '0;
  logic [19:0]       wsum     = '0;
  logic [4:0]        npings   = '0;
  logic [13:0]       dist_mm  = '0;
  logic [7:0]        n_samples  = RST_SAMPLE_COUNT;
  logic [15:0]       timeout_us = RST_ECHO_TIMEOUT;
  logic [15:0]       gap_len    = RST_GAP;

  result_t     tick_results_q[$];
  int unsigned mismatch_cnt   = 0;
  int unsigned items_sent     = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned snk_stall_pct  = 0;
  int unsigned echo_wait_pct  = 30;
  int unsigned pulse_hold_pct = 75;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  function automatic void report_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
    end
  endfunction

  function automatic logic [4:0] clamped_pings();
    return (n_samples > MaxSamples) ? 5'(MaxSamples) : 5'(n_samples);
  endfunction

  task automatic advance_ranger(input bit start, input bit echo);
    result_t     r;
    bit          timed_out;
    int unsigned avg;
    int unsigned mm;
    r = '0;
    r.busy_res = 1'b1;
    timed_out = 1'b0;
    case (ph)
      PH_IDLE: begin
        r.busy_res = 1'b0;
        if (start) begin
          if (clamped_pings() == 0) begin
            dist_mm = '0;
            r.done_res = 1'b1;
          end else begin
            ph = PH_SETUP;
            r.busy_res = 1'b1;
            tick_cnt = '0;
            pw = '0;
            wsum = '0;
            npings = '0;
          end
        end
      end
      PH_SETUP: begin
        ph = PH_TLOW;
        tick_cnt = '0;
      end
      PH_TLOW: begin
        tick_cnt++;
        if (tick_cnt >= LOW_TICKS) begin
          ph = PH_THIGH;
          tick_cnt = '0;
        end
      end
      PH_THIGH: begin
        r.trigger_level = 1'b1;
        tick_cnt++;
        if (tick_cnt >= HIGH_TICKS) begin
          ph = PH_WAIT;
          tick_cnt = '0;
          pw = '0;
        end
      end
      PH_WAIT: begin
        if (tick_cnt < TICK_MAX) tick_cnt++;
        if (tick_cnt >= timeout_us) begin
          timed_out = 1'b1;
        end else if (echo) begin
          ph = PH_PULSE;
          pw = 16'd1;
        end
      end
      PH_PULSE: begin
        if (!echo) begin
          wsum = wsum + 20'(pw);
          npings = npings + 5'd1;
          ph = PH_GAP;
          tick_cnt = '0;
        end else begin
          if (tick_cnt < TICK_MAX) tick_cnt++;
          if (pw < TICK_MAX) pw++;
          if (tick_cnt >= timeout_us) timed_out = 1'b1;
        end
      end
      PH_GAP: begin
        if (tick_cnt < gap_len) begin
          tick_cnt++;
        end else if (npings >= clamped_pings() && npings != 0) begin
          avg = wsum / npings;
          mm = (avg * 10) / UsPerCm;
          dist_mm = (mm > DIST_MAX) ? 14'(DIST_MAX) : 14'(mm);
          ph = PH_IDLE;
          r.busy_res = 1'b0;
          r.done_res = 1'b1;
        end else begin
          ph = PH_TLOW;
          tick_cnt = '0;
        end
      end
      default: begin
        ph = PH_IDLE;
        r.busy_res = 1'b0;
      end
    endcase
    if (timed_out) begin
      dist_mm = '0;
      ph = PH_IDLE;
      tick_cnt = '0;
      r.busy_res = 1'b0;
      r.done_res = 1'b1;
    end
    r.fail = timed_out;
    r.distance_mm = dist_mm;
    tick_results_q.push_back(r);
  endtask

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(result_t)-1:0];
      if (tick_results_q.size() == 0) begin
        report_mismatch("unexpected item", 0, out_tdata);
      end else begin
        want = tick_results_q.pop_front();
        if (got.trigger_level !== want.trigger_level)
          report_mismatch("trigger_level", want.trigger_level, got.trigger_level);
        if (got.busy_res !== want.busy_res)
          report_mismatch("busy_res", want.busy_res, got.busy_res);
        if (got.done_res !== want.done_res)
          report_mismatch("done_res", want.done_res, got.done_res);
        if (got.fail !== want.fail)
          report_mismatch("fail", want.fail, got.fail);
        if (got.distance_mm !== want.distance_mm)
          report_mismatch("distance_mm", want.distance_mm, got.distance_mm);
      end
    end
  end

  task automatic send_tick(input bit start, input bit echo);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, echo, start};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    advance_ranger(start, echo);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tick_results_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      REG_SAMPLE_COUNT: n_samples  = value[7:0];
      REG_ECHO_TIMEOUT: timeout_us = value;
      REG_GAP:          gap_len    = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_samples();
    case ($urandom_range(0, 19))
      0:       return 16'd0;
      1:       return 16'($urandom_range(17, 255));
      default: return 16'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [15:0] pick_timeout();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom_range(0, 3));
      1:       return 16'($urandom_range(0, 65535));
      2, 3:    return 16'($urandom_range(4, 30));
      default: return 16'($urandom_range(31, 2000));
    endcase
  endfunction

  function automatic logic [15:0] pick_gap();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom_range(20, 60));
      1:       return 16'd0;
      default: return 16'($urandom_range(0, 6));
    endcase
  endfunction

  task automatic retune_one();
    case ($urandom_range(0, 2))
      0:       write_reg(REG_SAMPLE_COUNT, pick_samples());
      1:       write_reg(REG_ECHO_TIMEOUT, pick_timeout());
      default: write_reg(REG_GAP, pick_gap());
    endcase
  endtask

  function automatic bit next_echo();
    case (ph)
      PH_WAIT:  return $urandom_range(0, 99) < echo_wait_pct;
      PH_PULSE: return $urandom_range(0, 99) < pulse_hold_pct;
      default:  return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // Starts a measurement and feeds ticks until it finishes. A retune may land mid-run.
  task automatic run_measurement(input bit allow_retune);
    bit retuned;
    retuned = !allow_retune;
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    while (ph != PH_IDLE) begin
      if (!retuned && $urandom_range(0, 99) < 3) begin
        retuned = 1'b1;
        wait_for_results();
        retune_one();
      end
      send_tick($urandom_range(0, 99) < 15, next_echo());
    end
  endtask

  task automatic test_zero_samples();
    write_reg(REG_SAMPLE_COUNT, 16'd0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    wait_for_results();
  endtask

  task automatic test_timeout_zero();
    write_reg(REG_SAMPLE_COUNT, 16'd1);
    write_reg(REG_ECHO_TIMEOUT, 16'd0);
    write_reg(REG_GAP, 16'd0);
    run_measurement(1'b0);
    wait_for_results();
  endtask

  task automatic test_clamped_samples();
    write_reg(REG_SAMPLE_COUNT, 16'd255);
    write_reg(REG_ECHO_TIMEOUT, 16'hFFFF);
    write_reg(REG_GAP, 16'd0);
    echo_wait_pct  = 40;
    pulse_hold_pct = 70;
    run_measurement(1'b0);
    wait_for_results();
  endtask

  // A long gap is cut short and the ping count lowered while the run sits in its gap.
  task automatic test_live_reconfig();
    write_reg(REG_SAMPLE_COUNT, 16'd2);
    write_reg(REG_ECHO_TIMEOUT, 16'hFFFF);
    write_reg(REG_GAP, 16'hFFFF);
    send_tick(1'b1, 1'b0);
    while (ph != PH_GAP) send_tick(1'b0, next_echo());
    repeat (6) send_tick(1'b1, 1'b0);
    wait_for_results();
    write_reg(REG_GAP, 16'd1);
    write_reg(REG_SAMPLE_COUNT, 16'd1);
    while (ph != PH_IDLE) send_tick(1'b0, next_echo());
    wait_for_results();
  endtask

  task automatic test_random_runs(input int unsigned n_items, input int unsigned idle_pct,
                                  input int unsigned stall_pct);
    int unsigned stop_at;
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
    stop_at = items_sent + n_items;
    wait_for_results();
    write_reg(REG_SAMPLE_COUNT, pick_samples());
    write_reg(REG_ECHO_TIMEOUT, pick_timeout());
    write_reg(REG_GAP, pick_gap());
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_for_results();
        retune_one();
      end
      repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'($urandom_range(0, 1)));
      echo_wait_pct  = $urandom_range(10, 60);
      pulse_hold_pct = ($urandom_range(0, 19) == 0) ? 97 : $urandom_range(40, 90);
      run_measurement(1'b1);
    end
    wait_for_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_samples();
    test_timeout_zero();
    test_clamped_samples();
    test_live_reconfig();
    test_random_runs(250, 0, 0);
    test_random_runs(250, 46, 0);
    test_random_runs(250, 0, 46);
    test_random_runs(250, 24, 24);
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    repeat (60) @(posedge clk);
    if (tick_results_q.size() != 0) begin
      report_mismatch("leftover expectations", 0, tick_results_q.size());
    end
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
